[sv/hte_pkg.sv]
`default_nettype none
package hte_pkg;

	localparam int NumSymbols = 128;
	localparam int MaxCodeLen = 32;
	localparam int SymW       = 7;
	localparam int CodeW      = 32;
	localparam int LenW       = 6;
	localparam int TotalW     = 48;
	localparam int OpW        = 2;
	localparam int WordW      = CodeW + 8;
	localparam int EntryW     = CodeW + LenW;

	typedef enum logic [OpW-1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ALIGN,
		ST_MERGE,
		ST_SEND,
		ST_FLUSH,
		ST_NOP,
		ST_ERR
	} state_t;

	typedef enum logic [2:0] {
		RES_LOAD,
		RES_BYTE,
		RES_FLUSH,
		RES_NOP,
		RES_ERR
	} res_kind_t;

	typedef struct packed {
		logic      capture;
		logic      write_entry;
		logic      align;
		logic      merge;
		logic      push;
		res_kind_t kind;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic out_free;
		logic enc_err;
		logic last_byte;
	} status_t;

endpackage
`default_nettype wire

[sv/hte_ctrl.sv]
`default_nettype none
module hte_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire hte_pkg::status_t status,
	output hte_pkg::cmd_t         cmd
);

	hte_pkg::state_t state_q;
	hte_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hte_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			hte_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (status.op)
						hte_pkg::OP_LOAD:   state_d = hte_pkg::ST_LOAD;
						hte_pkg::OP_ENCODE: state_d = hte_pkg::ST_ALIGN;
						hte_pkg::OP_FLUSH:  state_d = hte_pkg::ST_FLUSH;
						default:            state_d = hte_pkg::ST_NOP;
					endcase
				end
			end
			hte_pkg::ST_ALIGN: state_d = hte_pkg::ST_MERGE;
			hte_pkg::ST_MERGE: begin
				state_d = status.enc_err ? hte_pkg::ST_ERR : hte_pkg::ST_SEND;
			end
			hte_pkg::ST_SEND: begin
				if (status.out_free && status.last_byte) begin
					state_d = hte_pkg::ST_IDLE;
				end
			end
			hte_pkg::ST_LOAD, hte_pkg::ST_FLUSH, hte_pkg::ST_NOP, hte_pkg::ST_ERR: begin
				if (status.out_free) begin
					state_d = hte_pkg::ST_IDLE;
				end
			end
			default: state_d = hte_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd.capture     = 1'b0;
		cmd.write_entry = 1'b0;
		cmd.align       = 1'b0;
		cmd.merge       = 1'b0;
		cmd.push        = 1'b0;
		cmd.kind        = hte_pkg::RES_NOP;
		unique case (state_q)
			hte_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			hte_pkg::ST_LOAD: begin
				cmd.write_entry = status.out_free;
				cmd.push        = status.out_free;
				cmd.kind        = hte_pkg::RES_LOAD;
			end
			hte_pkg::ST_ALIGN: cmd.align = 1'b1;
			hte_pkg::ST_MERGE: cmd.merge = !status.enc_err;
			hte_pkg::ST_SEND: begin
				cmd.push = status.out_free;
				cmd.kind = hte_pkg::RES_BYTE;
			end
			hte_pkg::ST_FLUSH: begin
				cmd.push = status.out_free;
				cmd.kind = hte_pkg::RES_FLUSH;
			end
			hte_pkg::ST_NOP: begin
				cmd.push = status.out_free;
				cmd.kind = hte_pkg::RES_NOP;
			end
			hte_pkg::ST_ERR: begin
				cmd.push = status.out_free;
				cmd.kind = hte_pkg::RES_ERR;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[sv/hte_datapath.sv]
`default_nettype none
module hte_datapath #(
	parameter int NUM_SYMBOLS  = hte_pkg::NumSymbols,
	parameter int MAX_CODE_LEN = hte_pkg::MaxCodeLen
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire hte_pkg::cmd_t              cmd,
	output hte_pkg::status_t                status,
	input  wire logic [hte_pkg::OpW-1:0]    in_op,
	input  wire logic [hte_pkg::SymW-1:0]   in_symbol,
	input  wire logic [hte_pkg::CodeW-1:0]  in_code_word,
	input  wire logic [hte_pkg::LenW-1:0]   in_code_length,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic [7:0]                      out_byte,
	output logic                            byte_valid,
	output logic                            last_of_run,
	output logic [hte_pkg::TotalW-1:0]      total_bits,
	output logic                            error_flag
);

	localparam int IdxW     = (NUM_SYMBOLS > 2) ? $clog2(NUM_SYMBOLS) : 1;
	localparam int LenLimit = (MAX_CODE_LEN > hte_pkg::CodeW) ? hte_pkg::CodeW : MAX_CODE_LEN;
	localparam int CodeW    = hte_pkg::CodeW;
	localparam int LenW     = hte_pkg::LenW;
	localparam int WordW    = hte_pkg::WordW;

	logic [hte_pkg::EntryW-1:0] entry_mem_q [NUM_SYMBOLS];
	logic [NUM_SYMBOLS-1:0]     entry_valid_q;

	logic [hte_pkg::SymW-1:0]   sym_q;
	logic [CodeW-1:0]           code_in_q;
	logic [LenW-1:0]            len_in_q;
	logic [hte_pkg::EntryW-1:0] rd_entry_q;
	logic                       rd_valid_q;
	logic [CodeW-1:0]           code_al_q;
	logic [LenW-1:0]            enc_len_q;
	logic [WordW-1:0]           word_q;
	logic [2:0]                 nbytes_q;
	logic [7:0]                 pend_q;
	logic [2:0]                 pc_q;
	logic [hte_pkg::TotalW-1:0] bit_total_q;

	logic                       out_valid_q;
	logic [7:0]                 out_byte_q;
	logic                       out_bvalid_q;
	logic                       out_last_q;
	logic [hte_pkg::TotalW-1:0] out_total_q;
	logic                       out_err_q;

	logic [7:0]       in_sym8;
	logic [7:0]       sym8_q;
	logic [IdxW-1:0]  in_idx;
	logic [IdxW-1:0]  idx_q;
	logic             in_range_in;
	logic             in_range_q;
	logic             load_err;
	logic [LenW-1:0]  rd_len;
	logic [LenW-1:0]  rd_len_eff;
	logic [LenW-1:0]  sum;
	logic [WordW-1:0] word_new;
	logic [7:0]       pend_new;
	logic             out_free;
	logic             last_byte;

	logic [7:0]       res_byte;
	logic             res_bvalid;
	logic             res_last;
	logic             res_err;

	assign in_sym8     = {1'b0, in_symbol};
	assign sym8_q      = {1'b0, sym_q};
	assign in_idx      = in_sym8[IdxW-1:0];
	assign idx_q       = sym8_q[IdxW-1:0];
	assign in_range_in = {1'b0, in_sym8} < 9'(NUM_SYMBOLS);
	assign in_range_q  = {1'b0, sym8_q} < 9'(NUM_SYMBOLS);
	assign load_err    = !in_range_q || (len_in_q > LenW'(LenLimit));
	assign rd_len      = rd_entry_q[hte_pkg::EntryW-1 -: LenW];
	assign rd_len_eff  = rd_valid_q ? rd_len : '0;
	assign sum         = {3'b000, pc_q} + enc_len_q;
	assign word_new    = {pend_q, {CodeW{1'b0}}} | ({code_al_q, 8'h00} >> pc_q);
	assign out_free    = !out_valid_q || out_ready;
	assign last_byte   = (nbytes_q[2:1] == 2'b00);

	always_comb begin
		case (sum[5:3])
			3'd0:    pend_new = word_new[39:32];
			3'd1:    pend_new = word_new[31:24];
			3'd2:    pend_new = word_new[23:16];
			3'd3:    pend_new = word_new[15:8];
			3'd4:    pend_new = word_new[7:0];
			default: pend_new = 8'h00;
		endcase
	end

	assign status.op        = hte_pkg::op_t'(in_op);
	assign status.out_free  = out_free;
	assign status.enc_err   = (enc_len_q == '0);
	assign status.last_byte = last_byte;

	// entry store: written on a load, read as a new beat is taken
	always_ff @(posedge clk) begin
		if (cmd.write_entry && in_range_q) begin
			entry_mem_q[idx_q] <= {(load_err ? LenW'(0) : len_in_q), code_in_q};
		end
		if (cmd.capture) begin
			rd_entry_q <= entry_mem_q[in_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			rd_valid_q    <= 1'b0;
		end else begin
			if (cmd.write_entry && in_range_q) begin
				entry_valid_q[idx_q] <= 1'b1;
			end
			if (cmd.capture) begin
				rd_valid_q <= in_range_in && entry_valid_q[in_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sym_q     <= in_symbol;
			code_in_q <= in_code_word;
			len_in_q  <= in_code_length;
		end
		if (cmd.align) begin
			code_al_q <= rd_entry_q[CodeW-1:0] << (LenW'(CodeW) - rd_len_eff);
		end
		if (cmd.merge) begin
			word_q <= word_new;
		end else if (cmd.push && cmd.kind == hte_pkg::RES_BYTE && nbytes_q != 3'd0) begin
			word_q <= word_q << 8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_len_q   <= '0;
			nbytes_q    <= '0;
			pend_q      <= '0;
			pc_q        <= '0;
			bit_total_q <= '0;
		end else begin
			if (cmd.align) begin
				enc_len_q <= rd_len_eff;
			end
			if (cmd.merge) begin
				nbytes_q    <= sum[5:3];
				pc_q        <= sum[2:0];
				pend_q      <= pend_new;
				bit_total_q <= bit_total_q + hte_pkg::TotalW'(enc_len_q);
			end else if (cmd.push && cmd.kind == hte_pkg::RES_BYTE && nbytes_q != 3'd0) begin
				nbytes_q <= nbytes_q - 3'd1;
			end else if (cmd.push && cmd.kind == hte_pkg::RES_FLUSH) begin
				pend_q <= '0;
				pc_q   <= '0;
			end
		end
	end

	always_comb begin
		res_byte   = 8'h00;
		res_bvalid = 1'b0;
		res_last   = 1'b1;
		res_err    = 1'b0;
		unique case (cmd.kind)
			hte_pkg::RES_LOAD: res_err = load_err;
			hte_pkg::RES_BYTE: begin
				if (nbytes_q != 3'd0) begin
					res_byte   = word_q[WordW-1 -: 8];
					res_bvalid = 1'b1;
					res_last   = last_byte;
				end
			end
			hte_pkg::RES_FLUSH: begin
				if (pc_q != 3'd0) begin
					res_byte   = pend_q;
					res_bvalid = 1'b1;
				end
			end
			hte_pkg::RES_ERR: res_err = 1'b1;
			default: ;
		endcase
	end

	// output register, refilled as soon as its beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_byte_q   <= res_byte;
			out_bvalid_q <= res_bvalid;
			out_last_q   <= res_last;
			out_total_q  <= bit_total_q;
			out_err_q    <= res_err;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign byte_valid  = out_bvalid_q;
	assign last_of_run = out_last_q;
	assign total_bits  = out_total_q;
	assign error_flag  = out_err_q;

	a_pend_low_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & (8'hFF >> pc_q)) == 8'h00)
		else $error("pending byte has bits below its count");

	a_empty_beat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_bvalid_q |-> out_byte_q == 8'h00)
		else $error("beat without a byte carries data");

	a_err_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_err_q |-> !out_bvalid_q)
		else $error("error beat carries a byte");

	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		nbytes_q <= 3'd4)
		else $error("more than four bytes from one symbol");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> out_valid_q)
		else $error("pushed beat lost");

endmodule
`default_nettype wire

[sv/huffman_table_encoder.sv]
// encode: the accepted beat passes the entry store read, code alignment and merge steps, then result beats leave
//   one per cycle while the output is free (one to four byte beats, one empty beat, or one error beat)
// load, flush and unknown operations: one result beat, pushed from the state after the one that takes the beat
// one item at a time, set by the entry store read, code alignment and packing steps
// reset clears control, packer, bit count and the entry valid flags; code words stay
//   undefined until loaded, no clearing pass
`default_nettype none
module huffman_table_encoder #(
	parameter int NUM_SYMBOLS  = hte_pkg::NumSymbols,
	parameter int MAX_CODE_LEN = hte_pkg::MaxCodeLen
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // symbol, code_word, code_length
	input  wire logic [1:0]  s_axis_tuser,  // operation
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,  // out_byte, total_bits
	output logic [1:0]       m_axis_tuser,  // byte_valid, error_flag
	output logic             m_axis_tlast
);

	hte_pkg::cmd_t    cmd;
	hte_pkg::status_t status;

	logic [7:0]                 out_byte;
	logic                       byte_valid;
	logic                       error_flag;
	logic [hte_pkg::TotalW-1:0] total_bits;

	hte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	hte_datapath #(
		.NUM_SYMBOLS  (NUM_SYMBOLS),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.in_op          (s_axis_tuser),
		.in_symbol      (s_axis_tdata[6:0]),
		.in_code_word   (s_axis_tdata[38:7]),
		.in_code_length (s_axis_tdata[44:39]),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.last_of_run    (m_axis_tlast),
		.total_bits     (total_bits),
		.error_flag     (error_flag)
	);

	assign m_axis_tdata = {total_bits, out_byte};
	assign m_axis_tuser = {error_flag, byte_valid};

endmodule
`default_nettype wire

[tb/hte_checker.sv]
module huffman_stream_checker
	import hte_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // symbol, code_word, code_length
	input  wire logic [1:0]  s_axis_tuser,  // operation
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [55:0] m_axis_tdata,  // out_byte, total_bits
	input  wire logic [1:0]  m_axis_tuser,  // byte_valid, error_flag
	input  wire logic        m_axis_tlast,
	output int               mismatches,
	output int               beats_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bit [7:0]        out_byte;
		bit              byte_valid;
		bit              last_of_run;
		bit [TotalW-1:0] total_bits;
		bit              error_flag;
	} packed_beat_t;

	localparam int LenLimit = (MaxCodeLen > 32) ? 32 : MaxCodeLen;

	bit [CodeW-1:0]  code_tbl [NumSymbols];
	bit [LenW-1:0]   len_tbl [NumSymbols];
	bit [7:0]        pend_byte;
	int              pend_cnt;
	bit [TotalW-1:0] bit_count;
	packed_beat_t    packed_beats_due [$];

	task automatic huffman_pack_step(input op_t op, input bit [SymW-1:0] sym,
			input bit [CodeW-1:0] word, input bit [LenW-1:0] len);
		packed_beat_t run [$];
		packed_beat_t b;
		int i;
		b = '{default: 0};
		case (op)
			OP_LOAD: begin
				if (sym >= NumSymbols) begin
					b.error_flag = 1'b1;
				end else begin
					code_tbl[sym] = word;
					if (len > LenLimit) begin
						len_tbl[sym] = '0;
						b.error_flag = 1'b1;
					end else begin
						len_tbl[sym] = len;
					end
				end
				run.push_back(b);
			end
			OP_ENCODE: begin
				if (sym >= NumSymbols || len_tbl[sym] == 0) begin
					b.error_flag = 1'b1;
					run.push_back(b);
				end else begin
					for (i = int'(len_tbl[sym]) - 1; i >= 0; i--) begin
						pend_byte[7 - pend_cnt] = code_tbl[sym][i];
						pend_cnt++;
						bit_count++;
						if (pend_cnt == 8) begin
							b.out_byte = pend_byte;
							b.byte_valid = 1'b1;
							run.push_back(b);
							pend_byte = '0;
							pend_cnt = 0;
						end
					end
					// no byte completed: one empty beat
					if (run.size() == 0)
						run.push_back(b);
				end
			end
			OP_FLUSH: begin
				if (pend_cnt > 0) begin
					b.out_byte = pend_byte;
					b.byte_valid = 1'b1;
					pend_byte = '0;
					pend_cnt = 0;
				end
				run.push_back(b);
			end
			default: run.push_back(b);
		endcase
		foreach (run[k]) begin
			run[k].total_bits = bit_count;
			run[k].last_of_run = (k == run.size() - 1);
			packed_beats_due.push_back(run[k]);
		end
	endtask

	task automatic check_field(input string name, input logic [TotalW-1:0] want,
			input logic [TotalW-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		packed_beat_t exp_beat;
		if (!arst_n) begin
			foreach (len_tbl[k])
				len_tbl[k] = '0;
			pend_byte = '0;
			pend_cnt = 0;
			bit_count = '0;
			packed_beats_due.delete();
			mismatches = 0;
			beats_due = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				huffman_pack_step(op_t'(s_axis_tuser), s_axis_tdata[6:0], s_axis_tdata[38:7],
					s_axis_tdata[44:39]);
			if (m_axis_tvalid && m_axis_tready) begin
				if (packed_beats_due.size() == 0) begin
					$error("result beat with nothing expected: tdata %0h tuser %0h",
						m_axis_tdata, m_axis_tuser);
					mismatches++;
				end else begin
					exp_beat = packed_beats_due.pop_front();
					check_field("out_byte", exp_beat.out_byte, m_axis_tdata[7:0]);
					check_field("byte_valid", exp_beat.byte_valid, m_axis_tuser[0]);
					check_field("last_of_run", exp_beat.last_of_run, m_axis_tlast);
					check_field("total_bits", exp_beat.total_bits, m_axis_tdata[55:8]);
					check_field("error_flag", exp_beat.error_flag, m_axis_tuser[1]);
				end
			end
			beats_due = packed_beats_due.size();
		end
	end

endmodule

[tb/tb_huffman_table_encoder.sv]
module tb_huffman_table_encoder;
	timeunit 1ns;
	timeprecision 1ps;
	import hte_pkg::*;

	localparam int LenLimit = (MaxCodeLen > 32) ? 32 : MaxCodeLen;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	int          mismatches;
	int          beats_due;
	bit          jitter_on;
	int          stall_left;
	bit          has_code [NumSymbols];

	huffman_table_encoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	huffman_stream_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.beats_due     (beats_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!jitter_on || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	always @(negedge clk) begin
		int n;
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			n = pick_gap();
			m_axis_tready <= (n == 0);
			if (n > 0)
				stall_left = n - 1;
		end
	end

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_item(input op_t op, input logic [SymW-1:0] sym,
			input logic [CodeW-1:0] word, input logic [LenW-1:0] len);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, len, word, sym};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_entry(input logic [SymW-1:0] sym, input logic [CodeW-1:0] word,
			input logic [LenW-1:0] len);
		has_code[sym] = (len != 0 && len <= LenLimit);
		send_item(OP_LOAD, sym, word, len);
	endtask

	task automatic random_item();
		int r;
		int pick;
		logic [SymW-1:0] sym;
		logic [LenW-1:0] len;
		r = $urandom_range(0, 99);
		sym = SymW'($urandom_range(0, NumSymbols - 1));
		if (r < 15) begin
			pick = $urandom_range(0, 19);
			if (pick < 2)
				len = '0;
			else if (pick < 4)
				len = LenW'($urandom_range(LenLimit + 1, 63));
			else if (pick < 14)
				len = LenW'($urandom_range(1, 8));
			else
				len = LenW'($urandom_range(9, LenLimit));
			load_entry(sym, $urandom, len);
		end else if (r < 80) begin
			// mostly symbols that hold a code
			repeat (8)
				if (!has_code[sym])
					sym = SymW'($urandom_range(0, NumSymbols - 1));
			send_item(OP_ENCODE, sym, $urandom, LenW'($urandom_range(0, 63)));
		end else if (r < 92) begin
			send_item(OP_FLUSH, sym, $urandom, LenW'($urandom_range(0, 63)));
		end else begin
			send_item(OP_NONE, sym, $urandom, LenW'($urandom_range(0, 63)));
		end
	endtask

	initial begin
		#1000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		jitter_on = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty flush, absent symbol, unknown op, length extremes
		send_item(OP_FLUSH, '0, '0, '0);
		send_item(OP_ENCODE, 7'd5, '0, '0);
		send_item(OP_NONE, 7'h7f, '1, '1);
		load_entry(7'd0, 32'hffff_ffff, 6'(LenLimit));
		load_entry(7'd127, 32'h0000_0000, 6'd1);
		load_entry(7'd64, 32'h0000_00a5, 6'd8);
		load_entry(7'd1, 32'h1234_5678, 6'(LenLimit + 1));
		load_entry(7'd2, 32'hffff_ffff, 6'd63);
		send_item(OP_ENCODE, 7'd127, '0, '0);
		send_item(OP_ENCODE, 7'd0, '0, '0);
		send_item(OP_ENCODE, 7'd1, '0, '0);
		send_item(OP_ENCODE, 7'd2, '0, '0);
		send_item(OP_ENCODE, 7'd64, '0, '0);
		send_item(OP_FLUSH, '0, '0, '0);
		send_item(OP_FLUSH, '0, '0, '0);
		load_entry(7'd3, 32'hdead_beef, 6'd0);
		send_item(OP_ENCODE, 7'd3, '0, '0);
		send_item(OP_ENCODE, 7'd0, '0, '0);
		send_item(OP_ENCODE, 7'd64, '0, '0);
		send_item(OP_ENCODE, 7'd0, '0, '0);
		send_item(OP_NONE, '0, '0, '0);
		send_item(OP_FLUSH, '0, '0, '0);

		for (int ph = 0; ph < 4; ph++) begin
			jitter_on = (ph != 1);
			repeat (12)
				load_entry(SymW'($urandom_range(0, NumSymbols - 1)), $urandom,
					LenW'($urandom_range(1, LenLimit)));
			repeat (72)
				random_item();
		end
		send_item(OP_FLUSH, '0, '0, '0);
		s_axis_tvalid <= 1'b0;

		wait (beats_due == 0);
		repeat (16) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && beats_due == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[huffman_table_encoder.f]
sv/hte_pkg.sv
sv/hte_ctrl.sv
sv/hte_datapath.sv
sv/huffman_table_encoder.sv
tb/hte_checker.sv
tb/tb_huffman_table_encoder.sv
